FILE: rtl/gtp_pkg.sv
// shared types, widths and codes of the gray to packed pixel block
package gtp_pkg;

  localparam int COORD_BITS  = 12;
  localparam int ADDR_BITS   = 24;
  localparam int PIX_W       = 8;
  localparam int MODE_W      = 2;
  localparam int DIM_W       = COORD_BITS + 1;
  localparam int SG_W        = COORD_BITS - 2;
  localparam int PROD_W      = DIM_W + SG_W;
  localparam int COLB_W      = DIM_W - 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_IDX_W   = 3;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(1) << COORD_BITS;

  localparam logic [MODE_W-1:0] MODE_ONE_BIT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TWO_BIT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TWO_CLAMP = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CLAMP    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_STRIDE   = 3'd6;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [PIX_W-1:0]      clamp_level;
    logic [COORD_BITS-1:0] origin_x;
    logic [COORD_BITS-1:0] origin_y;
    logic [DIM_W-1:0]      region_width;
    logic [DIM_W-1:0]      region_height;
    logic [COORD_BITS-1:0] line_stride;
  } cfg_t;

  typedef struct packed {
    logic [PROD_W-1:0] row_prod;
    logic [SG_W-1:0]   row_oxg;
    logic [COLB_W-1:0] col_byte;
    logic [PIX_W-1:0]  bits;
    logic              last;
  } q_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic emit;
    logic rect_end;
    logic at_origin;
  } fr_stat_t;

endpackage

FILE: rtl/gtp_pixel_if.sv
// input channel carrying one gray pixel per beat
interface gtp_pixel_if import gtp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] gray_pixel;

  modport source (output valid, output gray_pixel, input ready);
  modport sink   (input valid, input gray_pixel, output ready);
endinterface

FILE: rtl/gtp_byte_if.sv
// result channel carrying one packed byte and its address per beat
interface gtp_byte_if import gtp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] byte_address;
  logic [PIX_W-1:0]     packed_bits;
  logic                 last_byte;

  modport source (output valid, output byte_address, output packed_bits, output last_byte,
                  input ready);
  modport sink   (input valid, input byte_address, input packed_bits, input last_byte,
                  output ready);
endinterface

FILE: rtl/gtp_cfg_regs.sv
// apb configuration register file
module gtp_cfg_regs import gtp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_MODE:     cfg_nxt.mode          = pwdata[MODE_W-1:0];
        REG_CLAMP:    cfg_nxt.clamp_level   = pwdata[PIX_W-1:0];
        REG_ORIGIN_X: cfg_nxt.origin_x      = pwdata[COORD_BITS-1:0];
        REG_ORIGIN_Y: cfg_nxt.origin_y      = pwdata[COORD_BITS-1:0];
        REG_WIDTH:    cfg_nxt.region_width  = pwdata[DIM_W-1:0];
        REG_HEIGHT:   cfg_nxt.region_height = pwdata[DIM_W-1:0];
        REG_STRIDE:   cfg_nxt.line_stride   = pwdata[COORD_BITS-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:     prdata = CFG_DATA_W'(cfg_r.mode);
      REG_CLAMP:    prdata = CFG_DATA_W'(cfg_r.clamp_level);
      REG_ORIGIN_X: prdata = CFG_DATA_W'(cfg_r.origin_x);
      REG_ORIGIN_Y: prdata = CFG_DATA_W'(cfg_r.origin_y);
      REG_WIDTH:    prdata = CFG_DATA_W'(cfg_r.region_width);
      REG_HEIGHT:   prdata = CFG_DATA_W'(cfg_r.region_height);
      REG_STRIDE:   prdata = CFG_DATA_W'(cfg_r.line_stride);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode          <= MODE_ONE_BIT;
      cfg_r.clamp_level   <= '1;
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.region_width  <= DIM_W'(8);
      cfg_r.region_height <= DIM_W'(1);
      cfg_r.line_stride   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/gtp_front.sv
// front end: pixel reduction, packing, raster counters and row base product
module gtp_front import gtp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  gtp_pixel_if.sink   in_if,
  input  q_stat_t     q_stat,
  output logic        push,
  output q_entry_t    push_entry,
  output fr_stat_t    stat
);

  logic [COORD_BITS-1:0] row_r,      row_nxt;
  logic [DIM_W-1:0]      col_r,      col_nxt;
  logic [PIX_W-1:0]      pack_r,     pack_nxt;
  logic [PROD_W-1:0]     row_prod_r, row_prod_nxt;
  logic [SG_W-1:0]       row_oxg_r,  row_oxg_nxt;

  logic                  accept;
  logic                  one_bit;
  logic [PIX_W-1:0]      pix_c;
  logic [2:0]            slot;
  logic [2:0]            last_slot;
  logic [PIX_W-1:0]      code;
  logic [PIX_W-1:0]      bits;
  logic [DIM_W-1:0]      w_lim;
  logic [DIM_W-1:0]      h_lim;
  logic [DIM_W-1:0]      w_sum;
  logic [DIM_W-1:0]      w_round;
  logic [DIM_W:0]        col_inc;
  logic [DIM_W-1:0]      row_inc;
  logic                  row_end;
  logic                  rect_end;
  logic                  row_start;
  logic                  emit;
  logic [SG_W-1:0]       stride_g;
  logic [SG_W-1:0]       oxg;
  logic [DIM_W-1:0]      yrow;
  logic [PROD_W-1:0]     mul;
  logic [COLB_W-1:0]     col_byte;

  assign in_if.ready = !q_stat.full;
  assign accept      = in_if.valid && in_if.ready;

  assign one_bit = (cfg.mode == MODE_ONE_BIT);
  assign pix_c   = (cfg.mode == MODE_TWO_CLAMP && in_if.gray_pixel > cfg.clamp_level) ?
                   cfg.clamp_level : in_if.gray_pixel;
  assign slot      = one_bit ? col_r[2:0] : {1'b0, col_r[1:0]};
  assign last_slot = one_bit ? 3'd7 : 3'd3;
  assign code      = one_bit ? ({pix_c[7], 7'b0} >> slot)
                             : ({pix_c[6], pix_c[7], 6'b0} >> {slot[1:0], 1'b0});
  assign bits      = pack_r | code;

  // dimension clamping and rounding to a whole group
  always_comb begin
    if (cfg.region_width == '0) begin
      w_lim = DIM_W'(1);
    end else if (cfg.region_width > DIM_MAX) begin
      w_lim = DIM_MAX;
    end else begin
      w_lim = cfg.region_width;
    end
    if (cfg.region_height == '0) begin
      h_lim = DIM_W'(1);
    end else if (cfg.region_height > DIM_MAX) begin
      h_lim = DIM_MAX;
    end else begin
      h_lim = cfg.region_height;
    end
  end

  assign w_sum   = w_lim + (one_bit ? DIM_W'(7) : DIM_W'(3));
  assign w_round = one_bit ? {w_sum[DIM_W-1:3], 3'b0} : {w_sum[DIM_W-1:2], 2'b0};

  assign col_inc   = {1'b0, col_r} + (DIM_W+1)'(1);
  assign row_inc   = {1'b0, row_r} + DIM_W'(1);
  assign row_end   = col_inc >= {1'b0, w_round};
  assign rect_end  = row_end && (row_inc >= h_lim);
  assign row_start = (col_r == '0);
  assign emit      = (slot == last_slot) || row_end;

  assign stride_g = one_bit ? {1'b0, cfg.line_stride[COORD_BITS-1:3]}
                            : cfg.line_stride[COORD_BITS-1:2];
  assign oxg      = one_bit ? {1'b0, cfg.origin_x[COORD_BITS-1:3]}
                            : cfg.origin_x[COORD_BITS-1:2];
  assign yrow     = {1'b0, cfg.origin_y} + {1'b0, row_r};
  assign mul      = yrow * stride_g;
  assign col_byte = one_bit ? COLB_W'(col_r >> 3) : COLB_W'(col_r >> 2);

  assign push                = accept && emit;
  assign push_entry.row_prod = row_start ? mul : row_prod_r;
  assign push_entry.row_oxg  = row_start ? oxg : row_oxg_r;
  assign push_entry.col_byte = col_byte;
  assign push_entry.bits     = bits;
  assign push_entry.last     = rect_end;

  assign stat.emit      = emit;
  assign stat.rect_end  = rect_end;
  assign stat.at_origin = (row_r == '0) && row_start;

  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    pack_nxt     = pack_r;
    row_prod_nxt = row_prod_r;
    row_oxg_nxt  = row_oxg_r;
    if (accept) begin
      pack_nxt = emit ? '0 : bits;
      if (row_start) begin
        row_prod_nxt = mul;
        row_oxg_nxt  = oxg;
      end
      if (rect_end) begin
        row_nxt = '0;
        col_nxt = '0;
      end else if (row_end) begin
        row_nxt = row_inc[COORD_BITS-1:0];
        col_nxt = '0;
      end else begin
        col_nxt = col_inc[DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      pack_r <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      pack_r <= pack_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_prod_r <= row_prod_nxt;
    row_oxg_r  <= row_oxg_nxt;
  end

endmodule

FILE: rtl/gtp_queue.sv
// short fifo of packed bytes between front and back
module gtp_queue import gtp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  stat
);

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r,    cnt_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: rtl/gtp_back.sv
// back end: byte address assembly and output register
module gtp_back import gtp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  q_entry_t   head,
  input  q_stat_t    q_stat,
  output logic       pop,
  gtp_byte_if.source out_if
);

  logic                 valid_r, valid_nxt;
  logic [ADDR_BITS-1:0] addr_r,  addr_nxt;
  logic [PIX_W-1:0]     bits_r,  bits_nxt;
  logic                 last_r,  last_nxt;

  assign pop = q_stat.valid && (!valid_r || out_if.ready);

  always_comb begin
    valid_nxt = valid_r;
    addr_nxt  = addr_r;
    bits_nxt  = bits_r;
    last_nxt  = last_r;
    if (pop) begin
      valid_nxt = 1'b1;
      addr_nxt  = ADDR_BITS'(head.row_prod) + ADDR_BITS'(head.row_oxg)
                + ADDR_BITS'(head.col_byte);
      bits_nxt  = head.bits;
      last_nxt  = head.last;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    bits_r <= bits_nxt;
    last_r <= last_nxt;
  end

  assign out_if.valid        = valid_r;
  assign out_if.byte_address = addr_r;
  assign out_if.packed_bits  = bits_r;
  assign out_if.last_byte    = last_r;

endmodule

FILE: rtl/gray_to_packed_low_depth_pixels.sv
// top level of the gray to packed low-depth pixel block
//
// in_if carries 8-bit gray pixels of a rectangle in raster order, one per beat.
// out_if carries one beat per completed byte: its byte address in the target
// buffer, the packed bits to be ORed into that byte, and a flag on the last
// byte of the rectangle. The APB port sets mode, clamp level, origin, size
// and line stride; write it only while no beats are in flight.
// One pixel is accepted every clock while the queue is not full. A completed
// byte enters the queue, then the output register once nothing is queued
// ahead of it and that register is free. The front end holds the raster
// counters and the row base multiply; a four-entry queue feeds the back end,
// which adds the origin and byte column offsets to the row base product.
// When out_if stalls, the output register holds its beat, the queue fills,
// and in_if.ready drops only once the queue is full.
// rst_n is synchronous: counters, queue and output valid clear and the
// registers return to their defaults; the next pixel starts a new rectangle.
module gray_to_packed_low_depth_pixels import gtp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  gtp_pixel_if.sink             in_if,
  gtp_byte_if.source            out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg;
  q_stat_t  q_stat;
  fr_stat_t fr_stat;
  q_entry_t push_entry;
  q_entry_t head;
  logic     push;
  logic     pop;

  gtp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gtp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_if      (in_if),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry),
    .stat       (fr_stat)
  );

  gtp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  gtp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_if (out_if)
  );

  // counters restart after the last pixel of a rectangle
  a_rect_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready && fr_stat.rect_end |=> fr_stat.at_origin)
    else $error("counters did not restart after rectangle end");

  // a completed byte with nothing ahead moves through the queue into the output register
  a_byte_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready && fr_stat.emit && !q_stat.valid && !out_if.valid
    |-> ##2 out_if.valid)
    else $error("completed byte did not reach the output");

  // a queued byte moves into an empty output register
  a_queue_drain: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.valid && !out_if.valid |=> out_if.valid)
    else $error("queued byte not moved to output register");

endmodule
